// ===== design/rfr_pkg.sv =====
// ----------------------------------------------------------------------------
// rfr_pkg
// Shared constants, codes and helpers for the response frame receiver.
// ----------------------------------------------------------------------------
package rfr_pkg;

  localparam int PAYLOAD_DEPTH = 32;
  localparam int ADDR_W        = $clog2(PAYLOAD_DEPTH);
  localparam int HDR_CHARS     = 6;
  localparam int CODE_END      = 14;
  localparam int POS_MAX       = CODE_END + PAYLOAD_DEPTH;
  localparam int POS_W         = $clog2(POS_MAX + 1);
  localparam int CNT_W         = 6;

  localparam logic [7:0] STX_BYTE = 8'h02;
  localparam logic [7:0] ETX_BYTE = 8'h03;

  // Frame status codes
  localparam logic [3:0] ST_OK       = 4'd0;
  localparam logic [3:0] ST_SHORT    = 4'd1;
  localparam logic [3:0] ST_BCC      = 4'd2;
  localparam logic [3:0] ST_NODE     = 4'd3;
  localparam logic [3:0] ST_SUBADDR  = 4'd4;
  localparam logic [3:0] ST_ENDCODE  = 4'd5;
  localparam logic [3:0] ST_COMMAND  = 4'd6;
  localparam logic [3:0] ST_RESPONSE = 4'd7;
  localparam logic [3:0] ST_OVERFLOW = 4'd8;
  localparam logic [3:0] ST_BADHEX   = 4'd9;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_NODE    = 2'd0;
  localparam logic [1:0] REG_SUBADDR = 2'd1;
  localparam logic [1:0] REG_COMMAND = 2'd2;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_digit_t;

  // Decode one ASCII hex character; ok drops on anything else.
  function automatic hex_digit_t hex_decode(input logic [7:0] c);
    hex_digit_t r;
    r.ok  = 1'b1;
    r.val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r.val = 4'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r.val = 4'(c - 8'h37);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r.val = 4'(c - 8'h57);
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

endpackage

// ===== design/response_frame_receiver_top.sv =====
// ----------------------------------------------------------------------------
// response_frame_receiver_top
// Receives serial response frames, checks them and streams out the payload.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one received byte per word. Bytes are dropped until STX;
//   the characters up to ETX are parsed, and the byte after ETX is the BCC.
//   On the BCC word the frame is judged. A good frame sends its payload
//   characters on m_axis (tuser = 0), then one status word (tuser = 1,
//   tlast = 1); a bad frame sends the status word alone.
//   Latency: the first result word is valid the cycle after the BCC word is
//   accepted. Throughput: one input word per cycle while collecting; the
//   drain sends one word per cycle while m_axis is ready, paced by the
//   payload memory's registered read (the next address is issued on the
//   accepting edge). While the drain runs, hunt bytes for the next frame
//   are still taken; a later byte of the frame waits until the status word
//   is gone. When m_axis stalls the output word holds and the drain pauses.
//   Reset (rst, synchronous) clears the parse state, the drain and the
//   configuration registers; the payload memory is not cleared, since each
//   entry is written before a frame reads it. The user writes configuration
//   over APB only while the block is idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module response_frame_receiver_top (
  input  logic        clk,
  input  logic        rst,
  // APB configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Input bytes
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  // Result words
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [7:0] payload_char, [11:8] frame_status,
                                      // [19:12] end_code, [35:20] response_code,
                                      // [41:36] payload_count, [47:42] zero
  output logic        m_axis_tuser,   // [0] item_kind
  output logic        m_axis_tlast    // last_item
);
  import rfr_pkg::*;

  localparam logic [1:0] PH_HUNT    = 2'd0;
  localparam logic [1:0] PH_COLLECT = 2'd1;
  localparam logic [1:0] PH_BCC     = 2'd2;

  localparam logic [1:0] OS_IDLE = 2'd0;
  localparam logic [1:0] OS_CHAR = 2'd1;
  localparam logic [1:0] OS_STAT = 2'd2;

  // Configuration registers
  logic [6:0]  cfg_node;
  logic [7:0]  cfg_sub;
  logic [15:0] cfg_cmd;

  // Parse state
  logic [1:0]       phase;
  logic [POS_W-1:0] byte_position;
  logic [7:0]       running_bcc;
  logic [6:0]       parsed_node;
  logic [7:0]       parsed_subaddr;
  logic [7:0]       parsed_endcode;
  logic [15:0]      parsed_command;
  logic [15:0]      parsed_response;
  logic             flag_ovf;
  logic             flag_badhex;

  // Drain state and snapshot of the judged frame
  logic [1:0]       ostate;
  logic [CNT_W-1:0] drain_idx;
  logic [CNT_W-1:0] snap_cnt;
  logic [3:0]       snap_status;
  logic [7:0]       snap_endcode;
  logic [15:0]      snap_resp;

  // Payload memory
  logic [7:0]        payload_mem [PAYLOAD_DEPTH];
  logic [7:0]        rd_data;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic              wr_en;

  logic in_acc;
  logic out_acc;
  logic cfg_wr;

  logic       node_ok;
  logic [3:0] node_digit;
  hex_digit_t hx;
  logic       is_etx;
  logic       is_bcc;
  logic [3:0] status;
  logic [CNT_W-1:0] cnt_judged;
  logic [POS_W-1:0] payload_off;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_node <= '0;
      cfg_sub  <= '0;
      cfg_cmd  <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_NODE:    cfg_node <= pwdata[6:0];
        REG_SUBADDR: cfg_sub  <= pwdata[7:0];
        REG_COMMAND: cfg_cmd  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_NODE:    prdata = {25'd0, cfg_node};
      REG_SUBADDR: prdata = {24'd0, cfg_sub};
      REG_COMMAND: prdata = {16'd0, cfg_cmd};
      default:     prdata = 32'd0;
    endcase
  end

  // ---------------- input handshake ----------------
  // Hunt bytes never touch the memory or the snapshot, so take them during
  // a drain; the frame's later characters and the BCC wait for the drain to finish.
  assign s_axis_tready = (ostate == OS_IDLE) || (phase == PH_HUNT);
  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  assign is_etx = (s_axis_tdata == ETX_BYTE);
  assign is_bcc = in_acc && (phase == PH_BCC);

  // Character decoders
  assign node_ok    = (s_axis_tdata >= 8'h30) && (s_axis_tdata <= 8'h39);
  assign node_digit = node_ok ? 4'(s_axis_tdata - 8'h30) : 4'd0;
  assign hx         = hex_decode(s_axis_tdata);

  assign payload_off = byte_position - POS_W'(CODE_END);
  assign wr_addr     = payload_off[ADDR_W-1:0];
  assign wr_en       = in_acc && (phase == PH_COLLECT) && !is_etx
                       && (byte_position >= POS_W'(CODE_END))
                       && (byte_position <  POS_W'(POS_MAX));

  // ---------------- frame judgment ----------------
  // First failing check wins.
  always_comb begin
    if (byte_position < POS_W'(HDR_CHARS))          status = ST_SHORT;
    else if (s_axis_tdata != running_bcc)           status = ST_BCC;
    else if (flag_badhex)                           status = ST_BADHEX;
    else if (parsed_node != cfg_node)               status = ST_NODE;
    else if (parsed_subaddr != cfg_sub)             status = ST_SUBADDR;
    else if (parsed_endcode != 8'd0)                status = ST_ENDCODE;
    else if (byte_position == POS_W'(HDR_CHARS))    status = ST_OK;
    else if (byte_position < POS_W'(CODE_END))      status = ST_SHORT;
    else if (parsed_command != cfg_cmd)             status = ST_COMMAND;
    else if (parsed_response != 16'd0)              status = ST_RESPONSE;
    else if (flag_ovf)                              status = ST_OVERFLOW;
    else                                            status = ST_OK;
  end

  assign cnt_judged = (status == ST_OK && byte_position > POS_W'(CODE_END))
                      ? CNT_W'(payload_off) : CNT_W'(0);

  // ---------------- parser ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HUNT;
      byte_position   <= '0;
      running_bcc     <= '0;
      parsed_node     <= '0;
      parsed_subaddr  <= '0;
      parsed_endcode  <= '0;
      parsed_command  <= '0;
      parsed_response <= '0;
      flag_ovf        <= 1'b0;
      flag_badhex     <= 1'b0;
    end else if (in_acc) begin
      unique case (phase)
        PH_HUNT: begin
          if (s_axis_tdata == STX_BYTE) begin
            // open a new frame
            byte_position   <= '0;
            running_bcc     <= '0;
            parsed_node     <= '0;
            parsed_subaddr  <= '0;
            parsed_endcode  <= '0;
            parsed_command  <= '0;
            parsed_response <= '0;
            flag_ovf        <= 1'b0;
            flag_badhex     <= 1'b0;
            phase           <= PH_COLLECT;
          end
        end
        PH_COLLECT: begin
          running_bcc <= running_bcc ^ s_axis_tdata;
          if (is_etx) begin
            phase <= PH_BCC;
          end else begin
            if (byte_position < POS_W'(2)) begin
              parsed_node <= 7'((11'(parsed_node) * 11'd10) + 11'(node_digit));
              if (!node_ok) flag_badhex <= 1'b1;
            end else if (byte_position < POS_W'(CODE_END)) begin
              if (byte_position < POS_W'(4))
                parsed_subaddr <= {parsed_subaddr[3:0], hx.val};
              else if (byte_position < POS_W'(HDR_CHARS))
                parsed_endcode <= {parsed_endcode[3:0], hx.val};
              else if (byte_position < POS_W'(10))
                parsed_command <= {parsed_command[11:0], hx.val};
              else
                parsed_response <= {parsed_response[11:0], hx.val};
              if (!hx.ok) flag_badhex <= 1'b1;
            end else if (byte_position >= POS_W'(POS_MAX)) begin
              // saturate and flag overflow
              flag_ovf <= 1'b1;
            end
            if (byte_position < POS_W'(POS_MAX))
              byte_position <= byte_position + POS_W'(1);
          end
        end
        PH_BCC: begin
          phase           <= PH_HUNT;
          byte_position   <= '0;
          running_bcc     <= '0;
          parsed_node     <= '0;
          parsed_subaddr  <= '0;
          parsed_endcode  <= '0;
          parsed_command  <= '0;
          parsed_response <= '0;
          flag_ovf        <= 1'b0;
          flag_badhex     <= 1'b0;
        end
        default: phase <= PH_HUNT;
      endcase
    end
  end

  // ---------------- payload memory ----------------
  // Outside a drain keep entry 0 on the read port, so the first payload
  // character is ready the cycle after the BCC word. During a drain issue
  // the next address on the accepting edge.
  always_comb begin
    if (ostate == OS_CHAR && out_acc) rd_addr = ADDR_W'(drain_idx + CNT_W'(1));
    else if (ostate == OS_CHAR)       rd_addr = ADDR_W'(drain_idx);
    else                              rd_addr = '0;
  end

  always_ff @(posedge clk) begin
    if (wr_en) payload_mem[wr_addr] <= s_axis_tdata;
    rd_data <= payload_mem[rd_addr];
  end

  // ---------------- drain sequencer ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      ostate    <= OS_IDLE;
      drain_idx <= '0;
    end else begin
      unique case (ostate)
        OS_IDLE: begin
          if (is_bcc) begin
            drain_idx <= '0;
            ostate    <= (cnt_judged != CNT_W'(0)) ? OS_CHAR : OS_STAT;
          end
        end
        OS_CHAR: begin
          if (out_acc) begin
            if (drain_idx == snap_cnt - CNT_W'(1)) ostate <= OS_STAT;
            else drain_idx <= drain_idx + CNT_W'(1);
          end
        end
        OS_STAT: begin
          if (out_acc) ostate <= OS_IDLE;
        end
        default: ostate <= OS_IDLE;
      endcase
    end
  end

  // Hold the judged frame's fields for the whole run of result words.
  always_ff @(posedge clk) begin
    if (is_bcc) begin
      snap_status  <= status;
      snap_cnt     <= cnt_judged;
      snap_endcode <= parsed_endcode;
      snap_resp    <= (byte_position >= POS_W'(CODE_END)) ? parsed_response : 16'd0;
    end
  end

  // ---------------- result word ----------------
  assign m_axis_tvalid = (ostate != OS_IDLE);
  assign m_axis_tuser  = (ostate == OS_STAT);
  assign m_axis_tlast  = (ostate == OS_STAT);
  assign m_axis_tdata  = {6'd0,
                          snap_cnt,
                          snap_resp,
                          snap_endcode,
                          (ostate == OS_STAT) ? snap_status : ST_OK,
                          (ostate == OS_STAT) ? 8'd0 : rd_data};

endmodule
